// ===== rtl/core/tcw_pkg.sv =====
// Shared types and constants for the text console cursor writer.
package tcw_pkg;

  localparam int unsigned ADDR_W  = 11;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned NIB_W   = 4;

  // control codes
  localparam logic [7:0] CODE_NEWLINE   = 8'h0A;
  localparam logic [7:0] CODE_RETURN    = 8'h0D;
  localparam logic [7:0] CODE_BACKSPACE = 8'h01;
  localparam logic [7:0] CODE_UP        = 8'h02;
  localparam logic [7:0] CODE_BLANK     = 8'h20;

  localparam logic [COLOR_W-1:0] CLEAR_COLOR = 8'h0F;

  // configuration register indexes
  localparam logic REG_FOREGROUND = 1'b0;
  localparam logic REG_BACKGROUND = 1'b1;

  localparam logic [NIB_W-1:0] FG_RESET = 4'hF;
  localparam logic [NIB_W-1:0] BG_RESET = 4'h0;

  typedef struct packed {
    logic              cell_write;
    logic [ADDR_W-1:0] cell_address;
    logic [WORD_W-1:0] cell_word;
    logic              clear_screen;
    logic [ADDR_W-1:0] cursor_position;
  } result_t;

endpackage

// ===== rtl/core/text_console_cursor_writer_top.sv =====
// Text console writer: position/color tracking with a registered result stage.
//
// Input channel (in_valid_i/in_ready_o): one word is either a character
// (kind_i = 0, char_code_i) or a new write position (kind_i = 1,
// new_column_i/new_row_i, saturated to the screen). Control codes: newline,
// return, backspace (blanks the cell) and cursor up. Every input word gives
// exactly one output word (out_valid_o/out_ready_i): an optional cell write,
// a clear-screen flag and the linear cursor position.
// The result is computed in one pass from the input and the position registers
// and lands in the output register, or in the skid while the receiver stalls.
// One word per cycle while the skid is empty; position update is one pass.
// When the receiver stalls, one extra word is caught in a skid register, so
// in_ready_o is a register output; it drops only while the skid is full.
// Reset homes the position, clears the cursor and loads white on black.
// cfg_we_i writes foreground (index 0) or background (index 1) and reloads
// the active color; write only while the block is idle.
module text_console_cursor_writer_top #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [tcw_pkg::NIB_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [7:0]                  char_code_i,
  input  logic [6:0]                  new_column_i,
  input  logic [4:0]                  new_row_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        cell_write_o,
  output logic [tcw_pkg::ADDR_W-1:0]  cell_address_o,
  output logic [tcw_pkg::WORD_W-1:0]  cell_word_o,
  output logic                        clear_screen_o,
  output logic [tcw_pkg::ADDR_W-1:0]  cursor_position_o
);

  localparam int unsigned COL_W = $clog2(COLUMNS);
  localparam int unsigned ROW_W = $clog2(ROWS);

  logic [COL_W-1:0]            col_q, col_d;
  logic [ROW_W-1:0]            row_q, row_d;
  logic [tcw_pkg::COLOR_W-1:0] color_q, color_d, step_color;
  logic [tcw_pkg::ADDR_W-1:0]  cursor_q, cursor_d;
  logic [tcw_pkg::NIB_W-1:0]   fg_q, fg_d, bg_q, bg_d;
  logic [COL_W-1:0]            step_col;
  logic [ROW_W-1:0]            step_row;
  logic [tcw_pkg::ADDR_W-1:0]  step_cursor;
  tcw_pkg::result_t            step_res;

  tcw_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic             out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic             in_fire, out_fire;

  tcw_step #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_step (
    .kind_i      (kind_i),
    .char_code_i (char_code_i),
    .new_column_i(new_column_i),
    .new_row_i   (new_row_i),
    .col_i       (col_q),
    .row_i       (row_q),
    .color_i     (color_q),
    .cursor_i    (cursor_q),
    .col_o       (step_col),
    .row_o       (step_row),
    .color_o     (step_color),
    .cursor_o    (step_cursor),
    .result_o    (step_res)
  );

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // position and color state
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    color_d  = color_q;
    cursor_d = cursor_q;
    fg_d     = fg_q;
    bg_d     = bg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        tcw_pkg::REG_FOREGROUND: begin
          fg_d    = cfg_data_i;
          color_d = {bg_q, cfg_data_i};
        end
        tcw_pkg::REG_BACKGROUND: begin
          bg_d    = cfg_data_i;
          color_d = {cfg_data_i, fg_q};
        end
        default: ;
      endcase
    end else if (in_fire) begin
      col_d    = step_col;
      row_d    = step_row;
      color_d  = step_color;
      cursor_d = step_cursor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      color_q  <= tcw_pkg::CLEAR_COLOR;
      cursor_q <= '0;
      fg_q     <= tcw_pkg::FG_RESET;
      bg_q     <= tcw_pkg::BG_RESET;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      color_q  <= color_d;
      cursor_q <= cursor_d;
      fg_q     <= fg_d;
      bg_q     <= bg_d;
    end
  end

  // output register plus skid
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = step_res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = step_res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o       = out_valid_q;
  assign cell_write_o      = out_q.cell_write;
  assign cell_address_o    = out_q.cell_address;
  assign cell_word_o       = out_q.cell_word;
  assign clear_screen_o    = out_q.clear_screen;
  assign cursor_position_o = out_q.cursor_position;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a word while output register is empty");

  a_clear_homes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clear_screen_o |-> cursor_position_o == '0)
    else $error("clear screen without cursor at home");

  a_fill_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !out_valid_q |=> out_valid_q)
    else $error("accepted word did not reach output register");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !skid_valid_q && !in_fire |=> !out_valid_q)
    else $error("output word repeated after it was taken");

endmodule

// ===== rtl/core/tcw_step.sv =====
// Next position, color, cursor and result word for one input word.
module tcw_step #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25,
  localparam int unsigned COL_W  = $clog2(COLUMNS),
  localparam int unsigned ROW_W  = $clog2(ROWS)
) (
  input  logic                          kind_i,
  input  logic [7:0]                    char_code_i,
  input  logic [6:0]                    new_column_i,
  input  logic [4:0]                    new_row_i,
  input  logic [COL_W-1:0]              col_i,
  input  logic [ROW_W-1:0]              row_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   color_i,
  input  logic [tcw_pkg::ADDR_W-1:0]    cursor_i,
  output logic [COL_W-1:0]              col_o,
  output logic [ROW_W-1:0]              row_o,
  output logic [tcw_pkg::COLOR_W-1:0]   color_o,
  output logic [tcw_pkg::ADDR_W-1:0]    cursor_o,
  output tcw_pkg::result_t              result_o
);

  // product width: row < 64, COLUMNS <= 128
  localparam int unsigned PROD_W = 14;

  function automatic logic [tcw_pkg::ADDR_W-1:0] cell_of(
    input logic [COL_W:0] c,
    input logic [ROW_W:0] r
  );
    logic [PROD_W-1:0] sum;
    sum = PROD_W'(r) * PROD_W'(COLUMNS) + PROD_W'(c);
    return sum[tcw_pkg::ADDR_W-1:0];
  endfunction

  logic [COL_W:0] col_w;
  logic [ROW_W:0] row_w;
  logic [COL_W:0] col_n;
  logic [ROW_W:0] row_n;
  logic [COL_W:0] col_inc;
  logic           wr;
  logic           wr_new_pos;  // backspace writes at the moved-to cell
  logic [7:0]     wr_char;
  logic           overflow;

  assign col_w   = (COL_W+1)'(col_i);
  assign row_w   = (ROW_W+1)'(row_i);
  assign col_inc = col_w + 1'b1;

  always_comb begin
    col_n      = col_w;
    row_n      = row_w;
    wr         = 1'b0;
    wr_new_pos = 1'b0;
    wr_char    = char_code_i;
    case (char_code_i)
      tcw_pkg::CODE_NEWLINE: begin
        row_n = row_w + 1'b1;
        col_n = '0;
      end
      tcw_pkg::CODE_RETURN: begin
        col_n = '0;
      end
      tcw_pkg::CODE_BACKSPACE: begin
        if (col_w != '0) begin
          col_n = col_w - 1'b1;
        end else if (row_w != '0) begin
          row_n = row_w - 1'b1;
          col_n = (COL_W+1)'(COLUMNS - 1);
        end
        wr         = 1'b1;
        wr_new_pos = 1'b1;
        wr_char    = tcw_pkg::CODE_BLANK;
      end
      tcw_pkg::CODE_UP: begin
        if (row_w != '0) begin
          row_n = row_w - 1'b1;
        end
      end
      default: begin
        wr = 1'b1;
        if (int'(col_inc) >= COLUMNS) begin
          col_n = '0;
          row_n = row_w + 1'b1;
        end else begin
          col_n = col_inc;
        end
      end
    endcase
  end

  assign overflow = (int'(row_n) >= ROWS);

  always_comb begin
    col_o    = col_i;
    row_o    = row_i;
    color_o  = color_i;
    cursor_o = cursor_i;
    result_o = '0;
    result_o.cursor_position = cursor_i;
    if (kind_i) begin
      col_o = (int'(new_column_i) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : COL_W'(new_column_i);
      row_o = (int'(new_row_i) > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(new_row_i);
    end else begin
      if (overflow) begin
        col_o   = '0;
        row_o   = '0;
        color_o = tcw_pkg::CLEAR_COLOR;
      end else begin
        col_o = col_n[COL_W-1:0];
        row_o = row_n[ROW_W-1:0];
      end
      cursor_o = overflow ? '0 : cell_of(col_n, row_n);
      result_o.cell_write      = wr;
      result_o.cell_address    = wr ? (wr_new_pos ? cell_of(col_n, row_n)
                                                  : cell_of(col_w, row_w)) : '0;
      result_o.cell_word       = wr ? {color_i, wr_char} : '0;
      result_o.clear_screen    = overflow;
      result_o.cursor_position = cursor_o;
    end
  end

endmodule

// ===== dv/console_write_checker.sv =====
// Console writer checker: tracks position and color, predicts each result word and compares.
`timescale 1ns / 100ps

module console_write_checker import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [NIB_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              kind_i,
  input  logic [7:0]        char_code_i,
  input  logic [6:0]        new_column_i,
  input  logic [4:0]        new_row_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              cell_write_i,
  input  logic [ADDR_W-1:0] cell_address_i,
  input  logic [WORD_W-1:0] cell_word_i,
  input  logic              clear_screen_i,
  input  logic [ADDR_W-1:0] cursor_position_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o,
  output int unsigned       clears_o
);

  // shadow of the console state
  logic [NIB_W-1:0]   fg_color;
  logic [NIB_W-1:0]   bg_color;
  logic [COLOR_W-1:0] attr;
  logic [ADDR_W-1:0]  cursor_cell;
  int                 pos_col;
  int                 pos_row;

  result_t expected_results[$];

  function automatic logic [ADDR_W-1:0] cell_index(input int c, input int r);
    int lin;
    lin = r * COLUMNS + c;
    return lin[ADDR_W-1:0];
  endfunction

  function automatic result_t console_step(input logic kind, input logic [7:0] code,
                                           input logic [6:0] ncol, input logic [4:0] nrow);
    result_t res;
    int      c;
    int      rw;
    res = '0;
    c   = pos_col;
    rw  = pos_row;
    if (kind) begin
      c  = (ncol > COLUMNS - 1) ? COLUMNS - 1 : ncol;
      rw = (nrow > ROWS - 1) ? ROWS - 1 : nrow;
    end else begin
      case (code)
        CODE_NEWLINE: begin
          rw++;
          c = 0;
        end
        CODE_RETURN: c = 0;
        CODE_BACKSPACE: begin
          if (c > 0) begin
            c--;
          end else if (rw > 0) begin
            rw--;
            c = COLUMNS - 1;
          end
          res.cell_write   = 1'b1;
          res.cell_address = cell_index(c, rw);
          res.cell_word    = {attr, CODE_BLANK};
        end
        CODE_UP: begin
          if (rw > 0) rw--;
        end
        default: begin
          res.cell_write   = 1'b1;
          res.cell_address = cell_index(c, rw);
          res.cell_word    = {attr, code};
          c++;
          if (c >= COLUMNS) begin
            c = 0;
            rw++;
          end
        end
      endcase
      // ran off the bottom: screen clear wins over the colors, position homes
      if (rw >= ROWS) begin
        res.clear_screen = 1'b1;
        attr = CLEAR_COLOR;
        c    = 0;
        rw   = 0;
      end
      cursor_cell = cell_index(c, rw);
    end
    pos_col = c;
    pos_row = rw;
    res.cursor_position = cursor_cell;
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fail_count_o < 40)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      fg_color     = FG_RESET;
      bg_color     = BG_RESET;
      attr         = CLEAR_COLOR;
      cursor_cell  = '0;
      pos_col      = 0;
      pos_row      = 0;
      expected_results.delete();
      fail_count_o = 0;
      checked_o    = 0;
      clears_o     = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_FOREGROUND) fg_color = cfg_data_i;
        else bg_color = cfg_data_i;
        attr = {bg_color, fg_color};
      end
      // result side first: an output word always belongs to an older input word
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report("result word with nothing pending", 32'(cursor_position_i), 0);
        end else begin
          want = expected_results.pop_front();
          checked_o++;
          if (want.clear_screen) clears_o++;
          if (cell_write_i !== want.cell_write)
            report("cell_write", 32'(cell_write_i), 32'(want.cell_write));
          if (cell_address_i !== want.cell_address)
            report("cell_address", 32'(cell_address_i), 32'(want.cell_address));
          if (cell_word_i !== want.cell_word)
            report("cell_word", 32'(cell_word_i), 32'(want.cell_word));
          if (clear_screen_i !== want.clear_screen)
            report("clear_screen", 32'(clear_screen_i), 32'(want.clear_screen));
          if (cursor_position_i !== want.cursor_position)
            report("cursor_position", 32'(cursor_position_i), 32'(want.cursor_position));
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.push_back(console_step(kind_i, char_code_i, new_column_i, new_row_i));
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== dv/text_console_cursor_writer_top_tb.sv =====
// Testbench top for the text console writer: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module text_console_cursor_writer_top_tb;
  import tcw_pkg::*;

  localparam int unsigned COLUMNS     = 80;
  localparam int unsigned ROWS        = 25;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PHASE_WORDS = 200;

  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_SLOW, SINK_HOLD} sink_mode_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_index_i;
  logic [NIB_W-1:0]  cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              kind_i;
  logic [7:0]        char_code_i;
  logic [6:0]        new_column_i;
  logic [4:0]        new_row_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              cell_write_o;
  logic [ADDR_W-1:0] cell_address_o;
  logic [WORD_W-1:0] cell_word_o;
  logic              clear_screen_o;
  logic [ADDR_W-1:0] cursor_position_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned clears;

  int unsigned words_sent;
  int unsigned color_writes;
  int unsigned holdoffs;
  int unsigned burst_left;
  bit          gaps_on;

  text_console_cursor_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .char_code_i      (char_code_i),
    .new_column_i     (new_column_i),
    .new_row_i        (new_row_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cell_write_o     (cell_write_o),
    .cell_address_o   (cell_address_o),
    .cell_word_o      (cell_word_o),
    .clear_screen_o   (clear_screen_o),
    .cursor_position_o(cursor_position_o)
  );

  console_write_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .kind_i           (kind_i),
    .char_code_i      (char_code_i),
    .new_column_i     (new_column_i),
    .new_row_i        (new_row_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cell_write_i     (cell_write_o),
    .cell_address_i   (cell_address_o),
    .cell_word_i      (cell_word_o),
    .clear_screen_i   (clear_screen_o),
    .cursor_position_i(cursor_position_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .clears_o         (clears)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d results still pending", CYCLE_LIMIT, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: phases of open, random, slow and fully held-off ready
  initial begin
    sink_mode_e mode;
    int         span;
    int         phase_no;
    out_ready_i = 1'b0;
    holdoffs    = 0;
    phase_no    = 0;
    forever begin
      phase_no++;
      if (phase_no == 3 || $urandom_range(0, 4) == 0) begin
        mode = SINK_HOLD;
        span = $urandom_range(40, 80);
        holdoffs++;
      end else begin
        mode = sink_mode_e'($urandom_range(0, 2));
        span = $urandom_range(20, 150);
      end
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          SINK_OPEN:   out_ready_i <= 1'b1;
          SINK_RANDOM: out_ready_i <= 1'($urandom_range(0, 1));
          SINK_SLOW:   out_ready_i <= ($urandom_range(0, 3) == 0);
          default:     out_ready_i <= 1'b0;
        endcase
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic offer_word(input logic kind, input logic [7:0] code,
                            input logic [6:0] col, input logic [4:0] row);
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    char_code_i  <= code;
    new_column_i <= col;
    new_row_i    <= row;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic offer_char(input logic [7:0] code);
    offer_word(1'b0, code, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)));
  endtask

  task automatic offer_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 58)      offer_char(8'($urandom_range(0, 255)));
    else if (pick < 73) offer_char(CODE_NEWLINE);
    else if (pick < 78) offer_char(CODE_RETURN);
    else if (pick < 86) offer_char(CODE_BACKSPACE);
    else if (pick < 91) offer_char(CODE_UP);
    else offer_word(1'b1, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                    5'($urandom_range(0, 31)));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_colors(input logic [NIB_W-1:0] fg, input logic [NIB_W-1:0] bg);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FOREGROUND;
    cfg_data_i  <= fg;
    @(negedge clk_i);
    cfg_index_i <= REG_BACKGROUND;
    cfg_data_i  <= bg;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    color_writes += 2;
  endtask

  initial begin
    logic [NIB_W-1:0] fg_sel [PHASES];
    logic [NIB_W-1:0] bg_sel [PHASES];
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_FOREGROUND;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    kind_i       = 1'b0;
    char_code_i  = '0;
    new_column_i = '0;
    new_row_i    = '0;
    words_sent   = 0;
    color_writes = 0;
    gaps_on      = 1'b1;
    burst_left   = $urandom_range(1, 16);
    fg_sel = '{4'h0, 4'hF, 4'h0, 4'hF, 4'($urandom_range(0, 15))};
    bg_sel = '{4'h0, 4'hF, 4'hF, 4'h0, 4'($urandom_range(0, 15))};

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part, reset colors
    offer_char(8'h00);
    offer_char(8'hFF);
    offer_char(8'h41);
    offer_char(CODE_BACKSPACE);
    offer_char(CODE_UP);                      // top row: stays put
    offer_char(CODE_RETURN);
    offer_char(CODE_BACKSPACE);               // at home: blanks cell 0
    offer_word(1'b1, 8'h00, 7'd127, 5'd31);   // saturates to last cell
    offer_char(8'h5A);                        // write last cell, wrap runs off the bottom
    offer_word(1'b1, 8'hFF, 7'd0, 5'd3);
    offer_char(CODE_BACKSPACE);               // back to previous row's last column
    offer_char(CODE_NEWLINE);
    offer_char(CODE_UP);
    offer_word(1'b1, 8'h00, 7'(COLUMNS - 1), 5'd10);
    offer_char(8'h78);                        // column wrap without clear
    offer_word(1'b1, 8'h00, 7'd10, 5'(ROWS - 1));
    offer_char(CODE_NEWLINE);                 // newline off the bottom
    offer_word(1'b1, 8'h00, 7'd0, 5'(ROWS - 1));
    offer_char(CODE_BACKSPACE);
    offer_word(1'b1, 8'h00, 7'd0, 5'd0);
    offer_char(8'h7E);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_colors(fg_sel[ph], bg_sel[ph]);
      gaps_on = (ph != 1);
      repeat (PHASE_WORDS) offer_random_item();
    end
    wait_idle();
    repeat (5) @(negedge clk_i);

    $display("Run covered %0d input words and %0d checked results, %0d screen clears,",
             words_sent, checked, clears);
    $display("%0d color register writes and %0d receiver hold-offs", color_writes, holdoffs);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
